FILE: design/tstc_pkg.sv
// Shared types and constants for the touch swipe/tap classifier.
package tstc_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 360;
  localparam int unsigned SCREEN_HEIGHT_DEF = 360;

  localparam int unsigned COORD_W  = 9;   // width of the coordinate ports
  localparam int unsigned THRESH_W = 9;
  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(50);

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_PREV   = 3'd1,
    ACT_NEXT   = 3'd2,
    ACT_TOGGLE = 3'd3,
    ACT_CLOSE  = 3'd4,
    ACT_MUTE   = 3'd5,
    ACT_UNMUTE = 3'd6,
    ACT_PLAY   = 3'd7
  } action_e;

  // UI context flags that travel with each sample
  typedef struct packed {
    logic standby;
    logic panel;
    logic usb;
    logic muted;
  } ctx_t;

endpackage

FILE: design/tstc_flip.sv
// One axis of the 180-degree rotation: clamp to the screen, then mirror.
module tstc_flip #(
  parameter int unsigned SIZE = tstc_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned CW   = 9
) (
  input  logic [tstc_pkg::COORD_W-1:0] raw_i,
  output logic [CW-1:0]                coord_o
);

  localparam int unsigned RW = (CW > tstc_pkg::COORD_W) ? CW : tstc_pkg::COORD_W;
  localparam logic [RW-1:0] TOP = RW'(SIZE - 1);

  logic [RW-1:0] raw_ext;
  logic [RW-1:0] clamped;

  assign raw_ext = RW'(raw_i);
  assign clamped = (raw_ext > TOP) ? TOP : raw_ext;
  assign coord_o = CW'(TOP - clamped);

endmodule

FILE: design/tstc_classify.sv
// Release-time gesture decode: dx/dy from start and last point, then priority pick.
module tstc_classify #(
  parameter int unsigned SCREEN_HEIGHT = tstc_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned CW            = 9
) (
  input  logic [CW-1:0]                 start_x_i,
  input  logic [CW-1:0]                 start_y_i,
  input  logic [CW-1:0]                 last_x_i,
  input  logic [CW-1:0]                 last_y_i,
  input  logic [tstc_pkg::THRESH_W-1:0] thresh_i,
  input  tstc_pkg::ctx_t                ctx_i,
  output tstc_pkg::action_e             action_o
);

  // magnitude width covers both |d| and the threshold
  localparam int unsigned AW = ((CW > tstc_pkg::THRESH_W) ? CW : tstc_pkg::THRESH_W) + 1;
  localparam logic [CW:0] TOP_BAND = (CW + 1)'(SCREEN_HEIGHT / 3);

  logic signed [CW:0] dx, dy;
  logic [AW-1:0]      ax, ay, th;
  logic               horiz, vert, top_start;

  assign dx = $signed({1'b0, last_x_i}) - $signed({1'b0, start_x_i});
  assign dy = $signed({1'b0, last_y_i}) - $signed({1'b0, start_y_i});
  assign ax = AW'(dx[CW] ? (CW + 1)'(-dx) : (CW + 1)'(dx));
  assign ay = AW'(dy[CW] ? (CW + 1)'(-dy) : (CW + 1)'(dy));
  assign th = AW'(thresh_i);

  assign horiz     = (ax >= th) && (ax >= ay);
  assign vert      = (ay >= th) && (ay > ax);
  assign top_start = {1'b0, start_y_i} < TOP_BAND;

  always_comb begin
    priority if (ctx_i.standby) begin
      action_o = tstc_pkg::ACT_NONE;
    end else if (horiz && !dx[CW] && (dx != '0)) begin
      action_o = tstc_pkg::ACT_PREV;
    end else if (horiz && dx[CW]) begin
      action_o = tstc_pkg::ACT_NEXT;
    end else if (vert && top_start && !dy[CW] && (dy != '0)) begin
      action_o = tstc_pkg::ACT_TOGGLE;
    end else if (ctx_i.panel) begin
      action_o = tstc_pkg::ACT_CLOSE;
    end else if (ctx_i.usb) begin
      action_o = ctx_i.muted ? tstc_pkg::ACT_UNMUTE : tstc_pkg::ACT_MUTE;
    end else begin
      action_o = tstc_pkg::ACT_PLAY;
    end
  end

endmodule

FILE: design/touch_swipe_tap_classifier_core.sv
// Top level of the touch swipe/tap classifier: sample register, tracking state, result register.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one polled touch sample per beat:
//   pressed flag, raw x/y and the UI context flags. Output channel (out_valid_o /
//   out_stall_i) returns exactly one result beat per sample: pointer state, rotated
//   point and the gesture action (nonzero only on the release that ends a touch).
//   Config channel (cfg_valid_i / cfg_ready_o) writes the swipe threshold; it is
//   always ready and should only be written while the block is idle.
// Timing:
//   A sample lands in the input register, passes through the flip and decode
//   logic and is captured in the result register once that register can load;
//   out_valid_o rises with the capture. Throughput is one sample per cycle while
//   out_stall_i is low, set by the single pass through the decode logic; the
//   tracking state updates as each sample moves on.
// Reset: both stages empty, no touch held, start/last point at 0, threshold 50.
// Stall: while out_stall_i holds a result, the input register still takes one
//   more sample; after that in_stall_o rises until the result beat leaves.
module touch_swipe_tap_classifier_core #(
  parameter int unsigned SCREEN_WIDTH  = tstc_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = tstc_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tstc_pkg::THRESH_W-1:0] cfg_data_i,
  // sample in
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          touch_pressed_i,
  input  logic [tstc_pkg::COORD_W-1:0]  raw_x_i,
  input  logic [tstc_pkg::COORD_W-1:0]  raw_y_i,
  input  logic                          standby_shown_i,
  input  logic                          panel_open_i,
  input  logic                          source_usb_i,
  input  logic                          muted_i,
  // result out
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          point_pressed_o,
  output logic [tstc_pkg::COORD_W-1:0]  point_x_o,
  output logic [tstc_pkg::COORD_W-1:0]  point_y_o,
  output logic [2:0]                    action_o
);

  localparam int unsigned MAX_DIM = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH
                                                                   : SCREEN_HEIGHT;
  localparam int unsigned CW = $clog2(MAX_DIM);

  // ---------------- config register ----------------
  logic [tstc_pkg::THRESH_W-1:0] thresh_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= tstc_pkg::THRESH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thresh_q <= cfg_data_i;
    end
  end

  // ---------------- input register ----------------
  logic                         in_vld_q;
  logic                         pressed_q;
  logic [tstc_pkg::COORD_W-1:0] raw_x_q, raw_y_q;
  tstc_pkg::ctx_t               ctx_q;

  logic out_load;   // result register can take a beat this cycle
  logic fire;       // sample in the input register moves to the result register
  logic in_take;

  assign out_load   = !out_valid_o || !out_stall_i;
  assign fire       = in_vld_q && out_load;
  assign in_stall_o = in_vld_q && !out_load;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pressed_q <= touch_pressed_i;
      raw_x_q   <= raw_x_i;
      raw_y_q   <= raw_y_i;
      ctx_q     <= '{standby: standby_shown_i, panel: panel_open_i,
                     usb: source_usb_i, muted: muted_i};
    end
  end

  // ---------------- rotation ----------------
  logic [CW-1:0] x_rot, y_rot;

  tstc_flip #(.SIZE(SCREEN_WIDTH), .CW(CW)) u_flip_x (
    .raw_i  (raw_x_q),
    .coord_o(x_rot)
  );

  tstc_flip #(.SIZE(SCREEN_HEIGHT), .CW(CW)) u_flip_y (
    .raw_i  (raw_y_q),
    .coord_o(y_rot)
  );

  // ---------------- touch tracking ----------------
  logic          held_q, held_d;
  logic [CW-1:0] start_x_q, start_x_d, start_y_q, start_y_d;
  logic [CW-1:0] last_x_q, last_x_d, last_y_q, last_y_d;

  always_comb begin
    held_d    = held_q;
    start_x_d = start_x_q;
    start_y_d = start_y_q;
    last_x_d  = last_x_q;
    last_y_d  = last_y_q;
    if (fire) begin
      if (pressed_q) begin
        if (!held_q) begin
          // press edge: latch the start point
          start_x_d = x_rot;
          start_y_d = y_rot;
        end
        held_d   = 1'b1;
        last_x_d = x_rot;
        last_y_d = y_rot;
      end else begin
        held_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= 1'b0;
      start_x_q <= '0;
      start_y_q <= '0;
      last_x_q  <= '0;
      last_y_q  <= '0;
    end else begin
      held_q    <= held_d;
      start_x_q <= start_x_d;
      start_y_q <= start_y_d;
      last_x_q  <= last_x_d;
      last_y_q  <= last_y_d;
    end
  end

  // ---------------- gesture decode ----------------
  tstc_pkg::action_e gesture;
  tstc_pkg::action_e action_d;

  tstc_classify #(.SCREEN_HEIGHT(SCREEN_HEIGHT), .CW(CW)) u_classify (
    .start_x_i(start_x_q),
    .start_y_i(start_y_q),
    .last_x_i (last_x_q),
    .last_y_i (last_y_q),
    .thresh_i (thresh_q),
    .ctx_i    (ctx_q),
    .action_o (gesture)
  );

  // only a release that ends a held touch reports a gesture
  assign action_d = (!pressed_q && held_q) ? gesture : tstc_pkg::ACT_NONE;

  // ---------------- result register ----------------
  logic                         out_vld_q;
  logic                         pt_pressed_q;
  logic [tstc_pkg::COORD_W-1:0] pt_x_q, pt_y_q;
  tstc_pkg::action_e            action_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pt_pressed_q <= pressed_q;
      // pressed: this sample; released: last held point
      pt_x_q       <= pressed_q ? tstc_pkg::COORD_W'(x_rot) : tstc_pkg::COORD_W'(last_x_q);
      pt_y_q       <= pressed_q ? tstc_pkg::COORD_W'(y_rot) : tstc_pkg::COORD_W'(last_y_q);
      action_q     <= action_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign point_pressed_o = pt_pressed_q;
  assign point_x_o       = pt_x_q;
  assign point_y_o       = pt_y_q;
  assign action_o        = action_q;

  // ---------------- assertions ----------------
  a_press_no_action : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && point_pressed_o |-> action_o == tstc_pkg::ACT_NONE)
    else $error("action reported on a pressed beat");

  a_press_sets_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && pressed_q |=> held_q)
    else $error("held not set after pressed beat");

  a_release_clears_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !pressed_q |=> !held_q)
    else $error("held not cleared after release beat");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_valid_o)
    else $error("input stalled with room in the pipe");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the touch swipe/tap classifier core.
module testbench;

  localparam int SCR_W        = tstc_pkg::SCREEN_WIDTH_DEF;
  localparam int SCR_H        = tstc_pkg::SCREEN_HEIGHT_DEF;
  localparam int CRD_W        = tstc_pkg::COORD_W;
  localparam int TH_W         = tstc_pkg::THRESH_W;
  localparam int PHASE_ITEMS  = 250;   // samples per threshold setting
  localparam int HANG_LIMIT   = 2000;  // cycles with no beat on either side
  localparam int IDLE_PCT     = 27;

  // One polled touch sample as it goes onto the input channel.
  typedef struct packed {
    logic                 pressed;
    logic [CRD_W-1:0]     raw_x;
    logic [CRD_W-1:0]     raw_y;
    tstc_pkg::ctx_t       ctx;
  } touch_smp_t;

  // One result beat: pointer state, rotated point, gesture.
  typedef struct packed {
    logic                 pressed;
    logic [CRD_W-1:0]     x;
    logic [CRD_W-1:0]     y;
    tstc_pkg::action_e    act;
  } touch_res_t;

  // A queued sample; fixed marks a directed row whose result is typed in.
  typedef struct packed {
    touch_smp_t smp;
    logic       fixed;
    touch_res_t want;
  } stim_t;

  // Directed table row. ctx bits: standby, panel, usb, muted.
  typedef struct packed {
    logic               pr;
    logic [CRD_W-1:0]   rx;
    logic [CRD_W-1:0]   ry;
    tstc_pkg::ctx_t     ctx;
    logic               fixed;
    touch_res_t         want;
  } row_t;

  localparam touch_res_t NO_RES = '{1'b0, 9'd0, 9'd0, tstc_pkg::ACT_NONE};

  // The reset, corner, off-screen, standby and no-touch rows have obvious
  // results; the rest go through the gesture predictor.
  row_t dir_tab [26] = '{
    // release straight out of reset: last point is the reset zero
    '{1'b0, 9'd0,   9'd0,   4'b0000, 1'b1, '{1'b0, 9'd0,   9'd0,   tstc_pkg::ACT_NONE}},
    // corner to corner: raw max flips to 0, raw 0 flips to 359
    '{1'b1, 9'd359, 9'd359, 4'b0000, 1'b1, '{1'b1, 9'd0,   9'd0,   tstc_pkg::ACT_NONE}},
    '{1'b1, 9'd0,   9'd0,   4'b0000, 1'b1, '{1'b1, 9'd359, 9'd359, tstc_pkg::ACT_NONE}},
    '{1'b0, 9'd0,   9'd0,   4'b0000, 1'b1, '{1'b0, 9'd359, 9'd359, tstc_pkg::ACT_PREV}},
    // off-screen raw clamps to the edge, then a motionless tap
    '{1'b1, 9'd511, 9'd511, 4'b0000, 1'b1, '{1'b1, 9'd0,   9'd0,   tstc_pkg::ACT_NONE}},
    '{1'b0, 9'd511, 9'd511, 4'b0000, 1'b1, '{1'b0, 9'd0,   9'd0,   tstc_pkg::ACT_PLAY}},
    // swipe left
    '{1'b1, 9'd0,   9'd180, 4'b0000, 1'b0, NO_RES},
    '{1'b1, 9'd300, 9'd180, 4'b0000, 1'b0, NO_RES},
    '{1'b0, 9'd0,   9'd0,   4'b0000, 1'b0, NO_RES},
    // downward from the top third
    '{1'b1, 9'd180, 9'd359, 4'b0000, 1'b0, NO_RES},
    '{1'b1, 9'd180, 9'd200, 4'b0000, 1'b0, NO_RES},
    '{1'b0, 9'd0,   9'd0,   4'b0100, 1'b0, NO_RES},
    // downward from mid screen with the panel open
    '{1'b1, 9'd180, 9'd200, 4'b0000, 1'b0, NO_RES},
    '{1'b1, 9'd180, 9'd0,   4'b0000, 1'b0, NO_RES},
    '{1'b0, 9'd0,   9'd0,   4'b0100, 1'b0, NO_RES},
    // USB taps, muted and not
    '{1'b1, 9'd100, 9'd100, 4'b0011, 1'b0, NO_RES},
    '{1'b0, 9'd100, 9'd100, 4'b0011, 1'b0, NO_RES},
    '{1'b1, 9'd100, 9'd100, 4'b0010, 1'b0, NO_RES},
    '{1'b0, 9'd100, 9'd100, 4'b0010, 1'b0, NO_RES},
    // a full swipe released in standby reports nothing
    '{1'b1, 9'd0,   9'd0,   4'b0000, 1'b0, NO_RES},
    '{1'b1, 9'd359, 9'd359, 4'b0000, 1'b0, NO_RES},
    '{1'b0, 9'd0,   9'd0,   4'b1111, 1'b1, '{1'b0, 9'd0,   9'd0,   tstc_pkg::ACT_NONE}},
    // release with no touch held, panel, usb and muted flags up
    '{1'b0, 9'd511, 9'd511, 4'b0111, 1'b1, '{1'b0, 9'd0,   9'd0,   tstc_pkg::ACT_NONE}},
    // displacement exactly at the reset threshold
    '{1'b1, 9'd200, 9'd200, 4'b0000, 1'b0, NO_RES},
    '{1'b1, 9'd150, 9'd200, 4'b0000, 1'b0, NO_RES},
    '{1'b0, 9'd0,   9'd0,   4'b0000, 1'b0, NO_RES}
  };

  // Threshold settings walked after the directed part; entry 4 is randomized.
  int cuts [6] = '{1, 359, 0, 511, 0, 50};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TH_W-1:0]     cfg_data = '0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                touch_pressed = 1'b0;
  logic [CRD_W-1:0]    raw_x = '0;
  logic [CRD_W-1:0]    raw_y = '0;
  logic                standby_shown = 1'b0;
  logic                panel_open = 1'b0;
  logic                source_usb = 1'b0;
  logic                muted = 1'b0;

  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                point_pressed;
  logic [CRD_W-1:0]    point_x;
  logic [CRD_W-1:0]    point_y;
  logic [2:0]          action;

  stim_t       sample_q [$];   // samples waiting to go out
  touch_res_t  pending_q [$];  // results owed by the block, oldest first
  stim_t       cur;            // sample on the input port
  int          queued = 0;
  int          fault_cnt = 0;
  int          hang_cnt = 0;
  bit          quiet = 1'b0;   // no idling on either side while set

  // Gesture tracker state, mirrors the block's own registers.
  logic [TH_W-1:0]     thresh = tstc_pkg::THRESH_RESET;
  logic [CRD_W-1:0]    org_x = '0;
  logic [CRD_W-1:0]    org_y = '0;
  logic [CRD_W-1:0]    end_x = '0;
  logic [CRD_W-1:0]    end_y = '0;
  logic                touch_down = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  touch_swipe_tap_classifier_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .touch_pressed_i (touch_pressed),
    .raw_x_i         (raw_x),
    .raw_y_i         (raw_y),
    .standby_shown_i (standby_shown),
    .panel_open_i    (panel_open),
    .source_usb_i    (source_usb),
    .muted_i         (muted),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .point_pressed_o (point_pressed),
    .point_x_o       (point_x),
    .point_y_o       (point_y),
    .action_o        (action)
  );

  // Rotate the sample, track the touch and classify on the release edge.
  function automatic touch_res_t track_sample(input touch_smp_t s);
    touch_res_t r;
    int cx, cy, dx, dy, ax, ay;
    bit horiz, vert;
    // clamp to the screen edge, then flip both axes
    cx = (int'(s.raw_x) > SCR_W - 1) ? 0 : SCR_W - 1 - int'(s.raw_x);
    cy = (int'(s.raw_y) > SCR_H - 1) ? 0 : SCR_H - 1 - int'(s.raw_y);
    r.pressed = s.pressed;
    r.act = tstc_pkg::ACT_NONE;
    if (s.pressed) begin
      if (!touch_down) begin
        org_x = CRD_W'(cx);
        org_y = CRD_W'(cy);
        touch_down = 1'b1;
      end
      end_x = CRD_W'(cx);
      end_y = CRD_W'(cy);
    end else if (touch_down) begin
      touch_down = 1'b0;
      if (!s.ctx.standby) begin
        dx = int'(end_x) - int'(org_x);
        dy = int'(end_y) - int'(org_y);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        // ties between the axes go to horizontal
        horiz = (ax >= int'(thresh)) && (ax >= ay);
        vert = (ay >= int'(thresh)) && (ay > ax);
        if (horiz && dx > 0) r.act = tstc_pkg::ACT_PREV;
        else if (horiz && dx < 0) r.act = tstc_pkg::ACT_NEXT;
        else if (vert && int'(org_y) < SCR_H / 3 && dy > 0) r.act = tstc_pkg::ACT_TOGGLE;
        else if (s.ctx.panel) r.act = tstc_pkg::ACT_CLOSE;
        else if (s.ctx.usb) r.act = s.ctx.muted ? tstc_pkg::ACT_UNMUTE : tstc_pkg::ACT_MUTE;
        else r.act = tstc_pkg::ACT_PLAY;
      end
    end
    // while released the port shows the last held point
    r.x = end_x;
    r.y = end_y;
    return r;
  endfunction

  function automatic int fit(input int v, input int size);
    return (v < 0) ? 0 : ((v > size - 1) ? size - 1 : v);
  endfunction

  // Queue one sample with random UI flags; now and then push it off-screen.
  task automatic push_sample(input logic pr, input int rx, input int ry);
    stim_t st;
    st = '0;
    if ($urandom_range(0, 19) == 0) rx = $urandom_range(SCR_W, 511);
    if ($urandom_range(0, 19) == 0) ry = $urandom_range(SCR_H, 511);
    st.smp.pressed = pr;
    st.smp.raw_x = CRD_W'(rx);
    st.smp.raw_y = CRD_W'(ry);
    st.smp.ctx.standby = ($urandom_range(0, 7) == 0);
    st.smp.ctx.panel = 1'($urandom_range(0, 1));
    st.smp.ctx.usb = 1'($urandom_range(0, 1));
    st.smp.ctx.muted = 1'($urandom_range(0, 1));
    sample_q.push_back(st);
    queued++;
  endtask

  // Press, wander, land near or far from the threshold, release.
  task automatic queue_gesture(input int th);
    int sx, sy, ex, ey, d;
    sx = $urandom_range(0, SCR_W - 1);
    sy = $urandom_range(0, SCR_H - 1);
    push_sample(1'b1, sx, sy);
    repeat ($urandom_range(0, 3))
      push_sample(1'b1, $urandom_range(0, SCR_W - 1), $urandom_range(0, SCR_H - 1));
    d = th + int'($urandom_range(0, 2)) - 1;   // one below, at, one above
    if ($urandom_range(0, 1)) d = -d;
    case ($urandom_range(0, 2))
      0: begin
        ex = $urandom_range(0, SCR_W - 1);
        ey = $urandom_range(0, SCR_H - 1);
      end
      1: begin
        ex = sx + d;
        ey = sy + int'($urandom_range(0, 4)) - 2;
      end
      default: begin
        ex = sx + int'($urandom_range(0, 4)) - 2;
        ey = sy + d;
      end
    endcase
    push_sample(1'b1, fit(ex, SCR_W), fit(ey, SCR_H));
    push_sample(1'b0, $urandom_range(0, 511), $urandom_range(0, 511));
  endtask

  // Mostly well-formed gestures, some raw noise (stray releases, odd presses).
  task automatic fill_phase(input int n, input int th);
    int stop;
    stop = queued + n;
    while (queued < stop) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3))
          push_sample(1'($urandom_range(0, 1)), $urandom_range(0, 511),
                      $urandom_range(0, 511));
      end else begin
        queue_gesture(th);
      end
    end
  endtask

  // Wait for every sample to go in and every result to come back out.
  task automatic drain();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_valid || pending_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_threshold(input int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= TH_W'(val);
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    thresh = TH_W'(val);
    @(negedge clk);
  endtask

  // Input side: predict at the accepting edge, then offer the next sample or idle.
  always @(posedge clk) begin : feed
    touch_res_t guess;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        guess = track_sample(cur.smp);
        if (cur.fixed) guess = cur.want;
        pending_q.push_back(guess);
      end
      if (!in_valid || !in_stall) begin
        if (sample_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur = sample_q.pop_front();
          in_valid <= 1'b1;
          touch_pressed <= cur.smp.pressed;
          raw_x <= cur.smp.raw_x;
          raw_y <= cur.smp.raw_y;
          standby_shown <= cur.smp.ctx.standby;
          panel_open <= cur.smp.ctx.panel;
          source_usb <= cur.smp.ctx.usb;
          muted <= cur.smp.ctx.muted;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: compare each result beat with the oldest expectation.
  always @(posedge clk) begin : check
    touch_res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          if (fault_cnt < 10)
            $display("unexpected result: pressed=%0d x=%0d y=%0d action=%0d",
                     point_pressed, point_x, point_y, action);
          fault_cnt++;
        end else begin
          want = pending_q.pop_front();
          if (point_pressed !== want.pressed || point_x !== want.x ||
              point_y !== want.y || action !== want.act) begin
            if (fault_cnt < 10)
              $display("mismatch: exp pressed=%0d x=%0d y=%0d action=%0d, got %0d %0d %0d %0d",
                       want.pressed, want.x, want.y, want.act,
                       point_pressed, point_x, point_y, action);
            fault_cnt++;
          end
        end
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Hang guard: too long with no beat on either channel ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        hang_cnt <= 0;
      end else if (hang_cnt >= HANG_LIMIT) begin
        $display("timeout: no beat for %0d cycles", HANG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        hang_cnt <= hang_cnt + 1;
      end
    end
  end

  initial begin : run
    stim_t st;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset threshold.
    foreach (dir_tab[i]) begin
      st.smp.pressed = dir_tab[i].pr;
      st.smp.raw_x = dir_tab[i].rx;
      st.smp.raw_y = dir_tab[i].ry;
      st.smp.ctx = dir_tab[i].ctx;
      st.fixed = dir_tab[i].fixed;
      st.want = dir_tab[i].want;
      sample_q.push_back(st);
    end
    drain();

    // Random part, one phase per threshold; phase 1 runs without any idling.
    cuts[4] = $urandom_range(1, 359);
    foreach (cuts[i]) begin
      quiet = (i == 1);
      write_threshold(cuts[i]);
      fill_phase(PHASE_ITEMS, cuts[i]);
      drain();
    end

    repeat (6) @(posedge clk);
    if (fault_cnt == 0 && pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/tstc_pkg.sv
design/tstc_flip.sv
design/tstc_classify.sv
design/touch_swipe_tap_classifier_core.sv
sim/testbench.sv
